// File: rtl/core/cop_pkg.sv
// ---------------------------------------------------------------------------
// cop_pkg: shared types and constants of the circle point generator
// opcodes, run length and the status word of the run queue
// ---------------------------------------------------------------------------
package cop_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // points emitted per run (eight-way symmetry)
  localparam int RUN_POINTS = 8;
  localparam int IDX_BITS   = $clog2(RUN_POINTS);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(RUN_POINTS - 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/cop_if.sv
// ---------------------------------------------------------------------------
// cop_if: stream channels of the circle point generator
// request channel (start / step) and point channel, valid/ready handshake
// ---------------------------------------------------------------------------
interface cop_req_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius;

  modport source (output valid, output opcode, output center_x, output center_y,
                  output radius, input ready);
  modport sink (input valid, input opcode, input center_x, input center_y,
                input radius, output ready);
endinterface

interface cop_pnt_if #(
  parameter int COORD_BITS = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] point_x;
  logic signed [COORD_BITS:0] point_y;
  logic                       last_of_run;
  logic                       circle_done;

  modport source (output valid, output point_x, output point_y, output last_of_run,
                  output circle_done, input ready);
  modport sink (input valid, input point_x, input point_y, input last_of_run,
                input circle_done, output ready);
endinterface

// File: rtl/core/cop_front.sv
// ---------------------------------------------------------------------------
// cop_front: request front end
// takes start/step beats, runs the midpoint decision update, queues runs
// ---------------------------------------------------------------------------
module cop_front
  import cop_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10,
  parameter int RUN_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  logic                clk,
  input  logic                rst,
  cop_req_if.sink             req,
  input  q_status_t           qs,
  output logic                push,
  output logic [RUN_BITS-1:0] push_data
);

  localparam int DW = RADIUS_BITS + 4;

  logic signed [COORD_BITS-1:0] cx, cx_next;
  logic signed [COORD_BITS-1:0] cy, cy_next;
  logic [RADIUS_BITS-1:0]       sx, sx_next;
  logic [RADIUS_BITS-1:0]       sy, sy_next;
  logic [DW-1:0]                dec, dec_next;
  logic                         drawing;
  logic                         accept;
  logic                         is_start;
  logic                         done;

  assign req.ready = !qs.full;
  assign accept    = req.valid && req.ready;
  assign is_start  = (req.opcode == OP_START);

  always_comb begin
    cx_next  = cx;
    cy_next  = cy;
    sx_next  = sx;
    sy_next  = sy;
    dec_next = dec;
    if (is_start) begin
      cx_next  = req.center_x;
      cy_next  = req.center_y;
      sx_next  = '0;
      sy_next  = req.radius;
      dec_next = DW'(3) - (DW'(req.radius) << 1);
    end else begin
      sx_next = sx + RADIUS_BITS'(1);
      if (dec[DW-1]) begin
        // decision negative: stay on this row
        dec_next = dec + (DW'(sx_next) << 2) + DW'(6);
      end else begin
        sy_next  = sy - RADIUS_BITS'(1);
        dec_next = dec + ((DW'(sx_next) - DW'(sy_next)) << 2) + DW'(10);
      end
    end
  end

  assign done      = !(sx_next < sy_next);
  assign push      = accept && (is_start || drawing);
  assign push_data = {cx_next, cy_next, sx_next, sy_next, done};

  always_ff @(posedge clk) begin
    if (rst) begin
      cx      <= '0;
      cy      <= '0;
      sx      <= '0;
      sy      <= '0;
      dec     <= '0;
      drawing <= 1'b0;
    end else if (push) begin
      cx      <= cx_next;
      cy      <= cy_next;
      sx      <= sx_next;
      sy      <= sy_next;
      dec     <= dec_next;
      drawing <= !done;
    end
  end

  // an active circle always has x below y
  a_draw_order: assert property (@(posedge clk) disable iff (rst)
    drawing |-> (sx < sy))
    else $error("active circle with x not below y");

endmodule

// File: rtl/core/cop_queue.sv
// ---------------------------------------------------------------------------
// cop_queue: run descriptor queue
// two-entry fifo between the front end and the point sequencer
// ---------------------------------------------------------------------------
module cop_queue
  import cop_pkg::*;
#(
  parameter int WIDTH = 45
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output q_status_t        qs
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign qs.full  = (count == 2'(DEPTH));
  assign qs.empty = (count == 2'd0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push && qs.full) |-> pop)
    else $error("run queue overrun");

endmodule

// File: rtl/core/cop_back.sv
// ---------------------------------------------------------------------------
// cop_back: point sequencer
// walks the eight symmetric points of one run into the output register
// ---------------------------------------------------------------------------
module cop_back
  import cop_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10,
  parameter int RUN_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [RUN_BITS-1:0] head,
  input  q_status_t           qs,
  output logic                pop,
  cop_pnt_if.source           pnt
);

  localparam int SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int PW = COORD_BITS + 1;

  logic [RUN_BITS-1:0]          run;
  logic                         busy;
  logic [IDX_BITS-1:0]          idx;
  logic                         adv;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic [RADIUS_BITS-1:0]       sx;
  logic [RADIUS_BITS-1:0]       sy;
  logic                         run_done;
  logic [RADIUS_BITS-1:0]       x_term;
  logic [RADIUS_BITS-1:0]       y_term;
  logic signed [SW-1:0]         cx_e;
  logic signed [SW-1:0]         cy_e;
  logic signed [SW-1:0]         x_e;
  logic signed [SW-1:0]         y_e;
  logic signed [SW-1:0]         px;
  logic signed [SW-1:0]         py;

  assign {cx, cy, sx, sy, run_done} = run;

  // idx[2] swaps the roles of x and y, idx[0] mirrors x, idx[1] mirrors y
  assign x_term = idx[2] ? sy : sx;
  assign y_term = idx[2] ? sx : sy;
  assign cx_e   = SW'(cx);
  assign cy_e   = SW'(cy);
  assign x_e    = signed'(SW'(x_term));
  assign y_e    = signed'(SW'(y_term));
  assign px     = idx[0] ? (cx_e - x_e) : (cx_e + x_e);
  assign py     = idx[1] ? (cy_e - y_e) : (cy_e + y_e);

  assign adv = busy && (!pnt.valid || pnt.ready);
  assign pop = !qs.empty && (!busy || (adv && idx == LAST_IDX));

  always_ff @(posedge clk) begin
    if (adv) begin
      pnt.point_x     <= px[PW-1:0];
      pnt.point_y     <= py[PW-1:0];
      pnt.last_of_run <= (idx == LAST_IDX);
      pnt.circle_done <= (idx == LAST_IDX) && run_done;
    end
    if (pop) begin
      run <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      pnt.valid <= 1'b0;
    end else begin
      if (adv) begin
        pnt.valid <= 1'b1;
      end else if (pnt.ready) begin
        pnt.valid <= 1'b0;
      end
      // a pop restarts the index, also on the last point of the previous run
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv) begin
        idx <= idx + IDX_BITS'(1);
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (idx == '0))
    else $error("point index moved while idle");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (pnt.valid && pnt.circle_done) |-> pnt.last_of_run)
    else $error("circle done flagged off the end of a run");

endmodule

// File: rtl/core/circle_octant_point_generator.sv
// ---------------------------------------------------------------------------
// circle_octant_point_generator: midpoint circle rasterizer
// start/step requests in, eight symmetric circle points per run out
// ---------------------------------------------------------------------------
// A start beat latches center and radius and queues the run for x = 0,
// y = radius; each step beat advances x by one, updates the midpoint
// decision value (and y when the decision is not negative) and queues the
// next run. A step with no circle in progress is accepted and
// yields nothing. Every run comes out as eight point beats in the order
// (cx+x,cy+y) (cx-x,cy+y) (cx+x,cy-y) (cx-x,cy-y) (cx+y,cy+x) (cx-y,cy+x)
// (cx+y,cy-x) (cx-y,cy-x); the eighth beat has last_of_run set, and also
// circle_done when x has reached y, after which the circle is inactive.
// A start during a circle abandons it. Sustained request rate is limited by
// the single point output, which moves one beat a cycle while the point
// sink is ready; the front end takes a request whenever the run queue is not
// full, and the two-run queue lets it run up to two requests ahead of the
// point sequencer. A request beat reaches the point output through a queue
// entry, the run register of the sequencer and the point output register.
// ---------------------------------------------------------------------------
module circle_octant_point_generator
  import cop_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input logic       clk,
  input logic       rst,
  cop_req_if.sink   req,
  cop_pnt_if.source pnt
);

  // run descriptor: center x, center y, x, y, done flag
  localparam int RUN_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

  logic                push;
  logic [RUN_BITS-1:0] push_data;
  logic                pop;
  logic [RUN_BITS-1:0] head;
  q_status_t           qs;

  // front end: decision update and run queueing
  cop_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .RUN_BITS    (RUN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .qs        (qs),
    .push      (push),
    .push_data (push_data)
  );

  // decouples request acceptance from point output
  cop_queue #(
    .WIDTH (RUN_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  // back end: eight point beats per run
  cop_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .RUN_BITS    (RUN_BITS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .qs   (qs),
    .pop  (pop),
    .pnt  (pnt)
  );

endmodule

// File: tb/sv/tb_circle_octant_point_generator.sv
// ---------------------------------------------------------------------------
// tb_circle_octant_point_generator: self-checking bench of the circle rasterizer
// drives start/step beats in random bursts, predicts the eight points of every
// run in an internal midpoint model and checks each point beat as it arrives
// ---------------------------------------------------------------------------
module tb_circle_octant_point_generator;
  import cop_pkg::*;

  localparam int CB = 12;
  localparam int RB = 10;
  // cycles with no beat moving on either channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;
  // settle time after the last expected point, covers the two-run queue
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    logic signed [CB:0] x;
    logic signed [CB:0] y;
    logic               last;
    logic               done;
  } point_t;

  logic clk;
  logic rst;

  cop_req_if #(.COORD_BITS(CB), .RADIUS_BITS(RB)) req_ch ();
  cop_pnt_if #(.COORD_BITS(CB)) pnt_ch ();

  circle_octant_point_generator #(
    .COORD_BITS (CB),
    .RADIUS_BITS(RB)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .pnt(pnt_ch)
  );

  // -------------------------------------------------------------------------
  // midpoint circle model: its own copy of center, octant point and decision
  // -------------------------------------------------------------------------
  logic signed [CB-1:0] circle_cx;
  logic signed [CB-1:0] circle_cy;
  logic [RB-1:0]        oct_x;
  logic [RB-1:0]        oct_y;
  logic signed [RB+3:0] midpoint_d;
  bit                   circle_live;

  // points still owed by the block, oldest first
  point_t expected_points[$];

  // run statistics
  int productive_items;
  int start_beats;
  int step_beats;
  int idle_steps;
  int circles_done;
  int points_checked;
  int mismatches;
  int idle_cycles;

  // sender burst control
  int burst_left;
  bit full_rate;

  function automatic void queue_point(int px, int py, bit last, bit done);
    point_t p;
    p.x    = (CB + 1)'(px);
    p.y    = (CB + 1)'(py);
    p.last = last;
    p.done = done;
    expected_points.push_back(p);
  endfunction

  // advance the model by one accepted request and queue the run it causes
  function automatic void rasterize_item(opcode_t op, logic signed [CB-1:0] cx,
                                         logic signed [CB-1:0] cy, logic [RB-1:0] r);
    int  x;
    int  y;
    int  ccx;
    int  ccy;
    bit  fin;
    if (op == OP_START) begin
      start_beats++;
      circle_cx  = cx;
      circle_cy  = cy;
      oct_x      = '0;
      oct_y      = r;
      midpoint_d = (RB + 4)'(3 - 2 * int'(r));
    end else begin
      step_beats++;
      // a step with no circle in progress is swallowed
      if (!circle_live) begin
        idle_steps++;
        return;
      end
      oct_x = oct_x + 1'b1;
      if (midpoint_d < 0) begin
        midpoint_d = (RB + 4)'(int'(midpoint_d) + 4 * int'(oct_x) + 6);
      end else begin
        oct_y      = oct_y - 1'b1;
        midpoint_d = (RB + 4)'(int'(midpoint_d) + 4 * (int'(oct_x) - int'(oct_y)) + 10);
      end
    end
    productive_items++;
    fin         = !(oct_x < oct_y);
    circle_live = !fin;
    if (fin) circles_done++;
    x   = int'(oct_x);
    y   = int'(oct_y);
    ccx = int'(circle_cx);
    ccy = int'(circle_cy);
    // eight-way symmetry, fixed emission order
    queue_point(ccx + x, ccy + y, 1'b0, 1'b0);
    queue_point(ccx - x, ccy + y, 1'b0, 1'b0);
    queue_point(ccx + x, ccy - y, 1'b0, 1'b0);
    queue_point(ccx - x, ccy - y, 1'b0, 1'b0);
    queue_point(ccx + y, ccy + x, 1'b0, 1'b0);
    queue_point(ccx - y, ccy + x, 1'b0, 1'b0);
    queue_point(ccx + y, ccy - x, 1'b0, 1'b0);
    queue_point(ccx - y, ccy - x, 1'b1, fin);
  endfunction

  function automatic void report_mismatch(string what, point_t want, point_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at beat %0d: expected x=%0d y=%0d last=%0b done=%0b, got x=%0d y=%0d last=%0b done=%0b",
               what, points_checked, want.x, want.y, want.last, want.done,
               got.x, got.y, got.last, got.done);
    end
  endfunction

  // -------------------------------------------------------------------------
  // clock and reset
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // point receiver: stalls follow a 16-bit pattern reloaded at random,
  // sometimes all ones so that long stretches run without stalls
  // -------------------------------------------------------------------------
  initial begin
    logic [15:0] stall_pattern;
    int          pos;
    pnt_ch.ready  = 1'b0;
    stall_pattern = 16'hffff;
    pos           = 0;
    forever begin
      @(negedge clk);
      if (pos == 0) begin
        if ($urandom_range(0, 3) == 0) stall_pattern = 16'hffff;
        else stall_pattern = 16'($urandom) | 16'h0001;
      end
      pnt_ch.ready = full_rate ? 1'b1 : stall_pattern[pos];
      pos = (pos + 1) % 16;
    end
  end

  // -------------------------------------------------------------------------
  // monitor: every accepted request feeds the model, every accepted point is
  // checked against the oldest expectation; also the no-progress watchdog
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    point_t got;
    point_t want;
    bit     moved;
    moved = 1'b0;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        rasterize_item(opcode_t'(req_ch.opcode), req_ch.center_x, req_ch.center_y,
                       req_ch.radius);
      end
      if (pnt_ch.valid && pnt_ch.ready) begin
        moved    = 1'b1;
        got.x    = pnt_ch.point_x;
        got.y    = pnt_ch.point_y;
        got.last = pnt_ch.last_of_run;
        got.done = pnt_ch.circle_done;
        if (expected_points.size() == 0) begin
          report_mismatch("no point expected", '0, got);
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
              got.done !== want.done) begin
            report_mismatch("field", want, got);
          end
        end
        points_checked++;
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no beat moved for %0d cycles, %0d points still owed",
                   IDLE_LIMIT, expected_points.size());
          $display("[circle_octant_point_generator] ERROR");
          $finish;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // request driver: one beat per call, bursts of random length separated by
  // random gaps outside full-rate mode; valid stays high between back-to-back calls
  // -------------------------------------------------------------------------
  task automatic send_request(opcode_t op, logic [CB-1:0] cx, logic [CB-1:0] cy,
                              logic [RB-1:0] r);
    if (!full_rate) begin
      if (burst_left == 0) begin
        req_ch.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    req_ch.valid    = 1'b1;
    req_ch.opcode   = op;
    req_ch.center_x = cx;
    req_ch.center_y = cy;
    req_ch.radius   = r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // step beats carry junk in the unused fields, the block must ignore it
  task automatic send_step();
    send_request(OP_STEP, CB'($urandom), CB'($urandom), RB'($urandom));
  endtask

  task automatic run_out_circle();
    while (circle_live) send_step();
  endtask

  // hold the sender off until every owed point has been seen
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // directed tests
  // -------------------------------------------------------------------------

  // nothing drawn yet: the step must vanish without output
  task automatic test_idle_step();
    send_step();
  endtask

  // zero radius at the most negative x / most positive y: eight copies of the
  // center, done at once, and the following step finds no circle
  task automatic test_zero_radius();
    send_request(OP_START, 12'h800, 12'h7ff, 10'd0);
    send_step();
  endtask

  // unit radius: one step ends it through the y-decrement branch
  task automatic test_unit_radius();
    send_request(OP_START, 12'h7ff, 12'h800, 10'd1);
    run_out_circle();
  endtask

  // largest radius at the positive corner, abandoned by a new start at the
  // negative corner whose circle takes both decision branches before ending
  task automatic test_abandon_and_extremes();
    send_request(OP_START, 12'h7ff, 12'h7ff, 10'h3ff);
    repeat (3) send_step();
    send_request(OP_START, 12'h800, 12'h800, 10'd5);
    run_out_circle();
    send_step();
  endtask

  // -------------------------------------------------------------------------
  // random tests
  // -------------------------------------------------------------------------

  // mostly complete small circles with random centers; some large radii cut
  // short, some circles abandoned mid-way, some stray steps
  task automatic test_random_circles(int item_count);
    int goal;
    int kind;
    goal = productive_items + item_count;
    while (productive_items < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_step();
      end else if (kind < 18) begin
        send_request(OP_START, CB'($urandom), CB'($urandom), RB'($urandom));
        repeat ($urandom_range(0, 6)) if (circle_live) send_step();
      end else begin
        send_request(OP_START, CB'($urandom), CB'($urandom), RB'($urandom_range(0, 20)));
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(0, 4)) if (circle_live) send_step();
        end else begin
          run_out_circle();
        end
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // back-to-back requests with the receiver never stalling
  task automatic test_full_rate_circles();
    full_rate = 1'b1;
    repeat (4) begin
      send_request(OP_START, CB'($urandom), CB'($urandom), RB'($urandom_range(2, 16)));
      run_out_circle();
    end
    wait_drained();
    full_rate = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_START;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    req_ch.radius   = '0;
    circle_cx       = '0;
    circle_cy       = '0;
    oct_x           = '0;
    oct_y           = '0;
    midpoint_d      = '0;
    circle_live     = 1'b0;
    burst_left      = 0;
    full_rate       = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_step();
    test_zero_radius();
    test_unit_radius();
    test_abandon_and_extremes();
    // let every directed point out before the random phase
    wait_drained();
    test_random_circles(RANDOM_ITEMS);
    test_full_rate_circles();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d start beats and %0d step beats (%0d on an idle rasterizer), %0d circles finished",
             start_beats, step_beats, idle_steps, circles_done);
    $display("%0d point beats compared, %0d mismatches", points_checked, mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("[circle_octant_point_generator] OK");
    end else begin
      $display("[circle_octant_point_generator] ERROR");
    end
    $finish;
  end

endmodule
